[hdl/fpa_pkg.sv]
// Package with opcodes, status codes, stage types and saturation helper for the fixed-point ALU.
`timescale 1ns / 1ps

package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_MIN   = 4'd4,
        OP_MAX   = 4'd5,
        OP_I2F   = 4'd6,
        OP_F2I   = 4'd7,
        OP_INC   = 4'd8,
        OP_DEC   = 4'd9
    } op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DBZ = 2'd2;

    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] res;
        logic [1:0]  status;
        logic        lt;
        logic        eq;
        logic        gt;
    } side_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } sat_t;

    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t s;
        if (v > 64'(MAX32)) begin
            s.sat   = 1'b1;
            s.value = MAX32;
        end else if (v < 64'(MIN32)) begin
            s.sat   = 1'b1;
            s.value = MIN32;
        end else begin
            s.sat   = 1'b0;
            s.value = v[31:0];
        end
        return s;
    endfunction

endpackage

[hdl/fpa_req_if.sv]
// Request channel interface of the fixed-point ALU.
`timescale 1ns / 1ps

interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface

[hdl/fpa_rsp_if.sv]
// Result channel interface of the fixed-point ALU.
`timescale 1ns / 1ps

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic [1:0]         status;

    modport source (output valid, output result_value, output a_less, output a_equal,
                    output a_greater, output status, input ready);
    modport sink (input valid, input result_value, input a_less, input a_equal,
                  input a_greater, input status, output ready);
endinterface

[hdl/fpa_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module fpa_div_pipe #(
    parameter int DW = 40
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [31:0]   den,
    input  logic          neg,
    output logic [DW-1:0] quo,
    output logic          quo_neg
);

    logic [31:0]   rem_reg [DW];
    logic [DW-1:0] num_reg [DW];
    logic [DW-1:0] quo_reg [DW];
    logic [31:0]   den_reg [DW];
    logic          neg_reg [DW];

    for (genvar i = 0; i < DW; i++) begin : g_stage
        logic [31:0]   rem_in;
        logic [DW-1:0] num_in;
        logic [DW-1:0] quo_in;
        logic [31:0]   den_in;
        logic          neg_in;
        logic [32:0]   trial;
        logic [32:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign den_in = den;
            assign neg_in = neg;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_in, num_in[DW-1]};
            diff  = trial - {1'b0, den_in};
            ge    = trial >= {1'b0, den_in};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[31:0] : trial[31:0];
                num_reg[i] <= num_in << 1;
                quo_reg[i] <= {quo_in[DW-2:0], ge};
                den_reg[i] <= den_in;
                neg_reg[i] <= neg_in;
            end
        end
    end

    assign quo     = quo_reg[DW-1];
    assign quo_neg = neg_reg[DW-1];

endmodule

[hdl/fpa_front.sv]
// Operand stage, product register, simple operations and side-data delay line.
`timescale 1ns / 1ps

module fpa_front #(
    parameter int FRAC_BITS = 8,
    parameter int DW        = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [3:0]         op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               out_valid,
    output fpa_pkg::side_t     out_side
);

    logic               v1_reg;
    logic [3:0]         op1_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] b1_reg;
    logic signed [63:0] prod1_reg;

    logic               vline_reg [DW-1];
    fpa_pkg::side_t     sline_reg [DW-1];
    fpa_pkg::side_t     side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= op;
            a1_reg    <= a;
            b1_reg    <= b;
            prod1_reg <= 64'(a) * 64'(b);
        end
    end

    always_comb
    begin
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] madj;
        fpa_pkg::sat_t      s;
        wa = 64'(a1_reg);
        wb = 64'(b1_reg);
        madj = prod1_reg + (prod1_reg[63] ? 64'((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
        s = '0;
        side_next        = '0;
        side_next.op     = op1_reg;
        side_next.lt     = a1_reg < b1_reg;
        side_next.eq     = a1_reg == b1_reg;
        side_next.gt     = a1_reg > b1_reg;
        case (op1_reg)
            fpa_pkg::OP_ADD: s = fpa_pkg::sat64(wa + wb);
            fpa_pkg::OP_SUB: s = fpa_pkg::sat64(wa - wb);
            fpa_pkg::OP_MUL: s = fpa_pkg::sat64(madj >>> FRAC_BITS);
            fpa_pkg::OP_MIN: s.value = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            fpa_pkg::OP_MAX: s.value = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            fpa_pkg::OP_I2F: s = fpa_pkg::sat64(wa <<< FRAC_BITS);
            fpa_pkg::OP_F2I: s.value = a1_reg >>> FRAC_BITS;
            fpa_pkg::OP_INC: s = fpa_pkg::sat64(wa + 64'sd1);
            fpa_pkg::OP_DEC: s = fpa_pkg::sat64(wa - 64'sd1);
            default:         s = '0;
        endcase
        side_next.res = s.value;
        if (op1_reg == fpa_pkg::OP_DIV)
        begin
            side_next.status = (b1_reg == 32'sd0) ? fpa_pkg::ST_DBZ : fpa_pkg::ST_OK;
        end else
        begin
            side_next.status = s.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DW - 1; k++)
            begin
                vline_reg[k] <= 1'b0;
            end
        end else if (en)
        begin
            vline_reg[0] <= v1_reg;
            for (int k = 1; k < DW - 1; k++)
            begin
                vline_reg[k] <= vline_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sline_reg[0] <= side_next;
            for (int k = 1; k < DW - 1; k++)
            begin
                sline_reg[k] <= sline_reg[k-1];
            end
        end
    end

    assign out_valid = vline_reg[DW-2];
    assign out_side  = sline_reg[DW-2];

endmodule

[hdl/fixed_point_alu.sv]
// Top level of the pipelined signed fixed-point ALU.
// The divider pipeline has one stage per quotient bit and is followed by the output register.
// Throughput: one item per cycle unless the result is stalled; the restoring divider pipeline sets the depth.
// A stalled result freezes every stage; nothing is dropped or repeated.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input logic          clk,
    input logic          rst_n,
    fpa_req_if.sink      req,
    fpa_rsp_if.source    rsp
);

    localparam int DW = 32 + FRAC_BITS;

    logic           en;
    logic           in_fire;
    logic [31:0]    ua;
    logic [31:0]    ub;
    logic [DW-1:0]  quo;
    logic           quo_neg;
    logic           side_valid;
    fpa_pkg::side_t side;

    logic               out_valid_reg;
    logic signed [31:0] out_res_reg;
    logic [1:0]         out_status_reg;
    logic               out_lt_reg;
    logic               out_eq_reg;
    logic               out_gt_reg;
    logic signed [31:0] res_next;
    logic [1:0]         status_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;
    assign in_fire   = req.valid && en;

    assign ua = req.operand_a[31] ? 32'(-req.operand_a) : req.operand_a;
    assign ub = req.operand_b[31] ? 32'(-req.operand_b) : req.operand_b;

    fpa_div_pipe #(
        .DW (DW)
    ) u_div (
        .clk     (clk),
        .en      (en),
        .num     (DW'(ua) << FRAC_BITS),
        .den     (ub),
        .neg     (req.operand_a[31] ^ req.operand_b[31]),
        .quo     (quo),
        .quo_neg (quo_neg)
    );

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_fire),
        .op        (req.req_type),
        .a         (req.operand_a),
        .b         (req.operand_b),
        .out_valid (side_valid),
        .out_side  (side)
    );

    always_comb
    begin
        res_next    = side.res;
        status_next = side.status;
        if (side.op == fpa_pkg::OP_DIV)
        begin
            if (side.status == fpa_pkg::ST_DBZ)
            begin
                res_next = '0;
            end else if (quo_neg)
            begin
                if (quo > DW'(64'h80000000))
                begin
                    res_next    = fpa_pkg::MIN32;
                    status_next = fpa_pkg::ST_SAT;
                end else
                begin
                    res_next = 32'(-quo);
                end
            end else
            begin
                if (quo > DW'(64'h7fffffff))
                begin
                    res_next    = fpa_pkg::MAX32;
                    status_next = fpa_pkg::ST_SAT;
                end else
                begin
                    res_next = quo[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (en)
        begin
            out_valid_reg <= side_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg    <= res_next;
            out_status_reg <= status_next;
            out_lt_reg     <= side.lt;
            out_eq_reg     <= side.eq;
            out_gt_reg     <= side.gt;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.a_less       = out_lt_reg;
    assign rsp.a_equal      = out_eq_reg;
    assign rsp.a_greater    = out_gt_reg;

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
        else $error("compare flags not one-hot");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == fpa_pkg::ST_DBZ |-> rsp.result_value == 32'sd0)
        else $error("divide by zero result not zero");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(side_valid) && $stable(side))
        else $error("pipeline moved during stall");

endmodule
